@@ design/catan_pkg.sv @@
// Shared types, widths and the arctangent table for the CORDIC phase unit.
// Depends on nothing; every other design file imports it.
package catan_pkg;

  localparam int DATA_W     = 32;
  localparam int ITERATIONS = 12;
  localparam int PI_UNITS   = 1073741824;
  localparam int TAB_SIZE   = 32;
  localparam int IDX_W      = $clog2(TAB_SIZE);
  localparam int NUM_STAGES = (ITERATIONS > TAB_SIZE - 1) ? TAB_SIZE - 1 : ITERATIONS;

  // The vector grows by the CORDIC gain (about 1.65) on top of sqrt(2).
  localparam int VEC_W = DATA_W + 3;
  localparam int ACC_W = DATA_W + 2;
  localparam int RES_W = DATA_W + 4;

  localparam real Pi = 3.14159265358979323846;

  typedef logic signed [ACC_W-1:0] catan_tab_t [TAB_SIZE];

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
    logic                    x_neg;
    logic                    y_neg;
  } catan_vec_t;

  // Entry i is round(atan(2^-i) * PI_UNITS / pi), rounded half up.
  // Entry 0 is exactly a quarter of half a turn.
  function automatic catan_tab_t build_atan_tab();
    catan_tab_t tab;
    real        v;
    tab[0] = ACC_W'((PI_UNITS + 2) / 4);
    for (int i = 1; i < TAB_SIZE; i++) begin
      v      = $atan(2.0 ** (-i)) * real'(PI_UNITS) / Pi;
      tab[i] = ACC_W'($rtoi(v + 0.5));
    end
    return tab;
  endfunction

  localparam catan_tab_t ATAN_TAB = build_atan_tab();

  // Division by 2^sh that truncates toward zero, as integer division does.
  function automatic logic signed [VEC_W-1:0] trunc_shift(
    input logic signed [VEC_W-1:0] v,
    input logic [IDX_W-1:0]        sh
  );
    logic [VEC_W-1:0]        bias;
    logic signed [VEC_W-1:0] tmp;
    bias = ~({VEC_W{1'b1}} << sh);
    tmp  = v[VEC_W-1] ? (v + $signed(bias)) : v;
    return tmp >>> sh;
  endfunction

endpackage

@@ design/catan_in_if.sv @@
// Request channel carrying one (x, y) sample pair with valid/ready handshake.
// Depends on catan_pkg for the field width.
interface catan_in_if;
  import catan_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_in;
  logic signed [DATA_W-1:0] y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink (input valid, input x_in, input y_in, output ready);
endinterface

@@ design/catan_out_if.sv @@
// Result channel carrying one phase angle with valid/ready handshake.
// Depends on catan_pkg for the field width.
interface catan_out_if;
  import catan_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] phase;

  modport source (output valid, output phase, input ready);
  modport sink (input valid, input phase, output ready);
endinterface

@@ design/catan_prep.sv @@
// Input stage: reflects a negative x into the right half plane and widens
// the vector for the rotation stages. Depends on catan_pkg and catan_in_if.
module catan_prep (
  input  logic                  clk,
  input  logic                  rst,
  catan_in_if.sink              sample,
  output logic                  dn_valid,
  output catan_pkg::catan_vec_t dn_data,
  input  logic                  dn_ready
);
  import catan_pkg::*;

  catan_vec_t              vec_next;
  logic signed [VEC_W-1:0] x_ext;

  assign sample.ready = !dn_valid || dn_ready;

  always_comb begin
    x_ext          = VEC_W'(sample.x_in);
    vec_next.x_neg = sample.x_in[DATA_W-1];
    vec_next.y_neg = sample.y_in[DATA_W-1];
    vec_next.x     = vec_next.x_neg ? -x_ext : x_ext;
    vec_next.y     = VEC_W'(sample.y_in);
    vec_next.acc   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (sample.ready) begin
      dn_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      dn_data <= vec_next;
    end
  end

endmodule

@@ design/catan_stage.sv @@
// One CORDIC vectoring micro-rotation with its own pipeline register.
// The stage number selects the shift and the table entry. Depends on catan_pkg.
module catan_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [catan_pkg::IDX_W-1:0]   idx,
  input  logic                          up_valid,
  input  catan_pkg::catan_vec_t         up_data,
  output logic                          up_ready,
  output logic                          dn_valid,
  output catan_pkg::catan_vec_t         dn_data,
  input  logic                          dn_ready
);
  import catan_pkg::*;

  catan_vec_t              vec_next;
  logic signed [VEC_W-1:0] x_sh;
  logic signed [VEC_W-1:0] y_sh;
  logic signed [ACC_W-1:0] step;

  assign up_ready = !dn_valid || dn_ready;

  // Rotate toward y = 0; both updates use the old x and y.
  always_comb begin
    x_sh           = trunc_shift(up_data.x, idx);
    y_sh           = trunc_shift(up_data.y, idx);
    step           = ATAN_TAB[idx];
    vec_next.x_neg = up_data.x_neg;
    vec_next.y_neg = up_data.y_neg;
    if (up_data.y[VEC_W-1]) begin
      vec_next.x   = up_data.x - y_sh;
      vec_next.y   = up_data.y + x_sh;
      vec_next.acc = up_data.acc - step;
    end else begin
      vec_next.x   = up_data.x + y_sh;
      vec_next.y   = up_data.y - x_sh;
      vec_next.acc = up_data.acc + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= vec_next;
    end
  end

endmodule

@@ design/catan_post.sv @@
// Output stage: quadrant correction for a reflected vector, saturation to
// 32 bits, and the result register. Depends on catan_pkg and catan_out_if.
module catan_post (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  input  catan_pkg::catan_vec_t up_data,
  output logic                  up_ready,
  catan_out_if.source           result
);
  import catan_pkg::*;

  localparam logic signed [RES_W-1:0] PI_RES = RES_W'(PI_UNITS);
  localparam logic signed [RES_W-1:0] SAT_MAX =
    {{(RES_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN =
    {{(RES_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic signed [RES_W-1:0]  acc_ext;
  logic signed [RES_W-1:0]  res;
  logic signed [DATA_W-1:0] phase_next;

  assign up_ready = !result.valid || result.ready;

  always_comb begin
    acc_ext = $signed({{(RES_W-ACC_W){up_data.acc[ACC_W-1]}}, up_data.acc});
    if (!up_data.x_neg) begin
      res = acc_ext;
    end else if (up_data.y_neg) begin
      res = -PI_RES - acc_ext;
    end else begin
      res = PI_RES - acc_ext;
    end
    if (res > SAT_MAX) begin
      phase_next = SAT_MAX[DATA_W-1:0];
    end else if (res < SAT_MIN) begin
      phase_next = SAT_MIN[DATA_W-1:0];
    end else begin
      phase_next = res[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result.phase <= phase_next;
    end
  end

endmodule

@@ design/cordic_atan2_phase_unit.sv @@
// Four-quadrant phase of a signed (x, y) pair by pipelined CORDIC vectoring.
// Input channel "sample" takes x_in and y_in; output channel "result" gives
// phase, where PI_UNITS is half a turn, saturated to 32 bits.
// Both channels use valid/ready; a request moves when both are high.
// Structure: one input stage (reflects negative x), one register stage per
// micro-rotation (12), and one output stage (quadrant fix-up, saturation).
// A request passes the input, rotation and output registers in order; the
// pipeline takes one request per cycle while the result channel does not
// stall, set by one rotation stage per iteration.
// Every stage holds a valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up and a stall on the result channel
// backs up stage by stage; nothing is dropped or repeated. The input keeps
// accepting while any stage is empty, even while a result waits.
// Synchronous reset clears all valid bits; the pipeline is empty after it.
// Depends on catan_pkg, catan_in_if, catan_out_if, catan_prep,
// catan_stage and catan_post.
module cordic_atan2_phase_unit (
  input  logic        clk,
  input  logic        rst,
  catan_in_if.sink    sample,
  catan_out_if.source result
);
  import catan_pkg::*;

  logic       pipe_valid [NUM_STAGES+1];
  logic       pipe_ready [NUM_STAGES+1];
  catan_vec_t pipe_data  [NUM_STAGES+1];

  catan_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .dn_valid (pipe_valid[0]),
    .dn_data  (pipe_data[0]),
    .dn_ready (pipe_ready[0])
  );

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    catan_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(k)),
      .up_valid (pipe_valid[k]),
      .up_data  (pipe_data[k]),
      .up_ready (pipe_ready[k]),
      .dn_valid (pipe_valid[k+1]),
      .dn_data  (pipe_data[k+1]),
      .dn_ready (pipe_ready[k+1])
    );
  end

  catan_post u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pipe_valid[NUM_STAGES]),
    .up_data  (pipe_data[NUM_STAGES]),
    .up_ready (pipe_ready[NUM_STAGES]),
    .result   (result)
  );

endmodule
